@@ design/etok_pkg.sv @@
// Shared constants, types and character classes for the expression tokenizer.
package etok_pkg;

    // Longest token chunk, and the width of the character count
    localparam int TOKEN_MAX = 32;
    localparam int CNT_W     = 6;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int FILL_W     = 3;

    // Token kind codes
    localparam logic [1:0] KIND_IDENT = 2'd0;
    localparam logic [1:0] KIND_OP    = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    // Character codes that the rules name
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AT    = 8'h40;

    // One result item
    typedef struct packed {
        logic [7:0] token_char;
        logic [1:0] token_kind;
        logic       token_end;
        logic       expression_done;
        logic       item_last;
    } res_t;

    // Results produced by one accepted item, first in r0
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic is_ident(input logic [7:0] c);
        is_ident = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_HASH ||
                   c == CH_AT;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        is_op = c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                c == CH_PCT || c == CH_LPAR || c == CH_RPAR || c == CH_LT ||
                c == CH_GT || c == CH_BANG || c == CH_EQ || c == CH_AMP ||
                c == CH_BAR;
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        is_sign = c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic [1:0] kind_of(input logic [7:0] c);
        if (is_ident(c))
            kind_of = KIND_IDENT;
        else if (is_op(c))
            kind_of = KIND_OP;
        else
            kind_of = KIND_OTHER;
    endfunction

endpackage

@@ design/expression_tokenizer.sv @@
// Top level of the expression tokenizer: lookahead lexer feeding a result queue.
//
//  Channel   Direction  tdata            tuser                              tlast
//  s_axis    in         character        -                                  end_of_expression
//  m_axis    out        token_char       kind, token_end, expression_done   item_last
//
// One input item is taken per cycle while s_axis_tready is high; each gives zero,
// one or two result items, and results leave at one per cycle while m_axis_tready
// is high, from a four-entry queue. s_axis_tready is high while the queue has room
// for two results, so input stalls only when m_axis is held off. Reset clears the
// lookahead and the queue.
module expression_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] token_char
    output logic [3:0]  m_axis_tuser,   // [1:0] token_kind, [2] token_end,
                                        // [3] expression_done
    output logic        m_axis_tlast
);

    etok_pkg::push_t push;
    etok_pkg::res_t  out_res;
    logic            room;
    logic            in_fire;

    assign s_axis_tready = room;
    assign in_fire       = s_axis_tvalid && room;

    etok_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_char (s_axis_tdata),
        .in_eoe  (s_axis_tlast),
        .push    (push)
    );

    etok_out_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Unpack the head result onto the stream
    assign m_axis_tdata = out_res.token_char;
    assign m_axis_tuser = {out_res.expression_done, out_res.token_end, out_res.token_kind};
    assign m_axis_tlast = out_res.item_last;

endmodule

@@ design/etok_lexer.sv @@
// Lookahead register and token decision: turns one item into up to two results.
module etok_lexer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          in_char,
    input  logic                in_eoe,
    output etok_pkg::push_t     push
);

    logic [7:0]                held_char_reg, held_char_next;
    logic                      held_valid_reg, held_valid_next;
    logic [1:0]                held_kind_reg, held_kind_next;
    logic [etok_pkg::CNT_W-1:0] count_reg, count_next;

    logic       cont;
    logic [6:0] pos;
    logic [1:0] new_kind;
    etok_pkg::res_t held_res;
    etok_pkg::res_t new_res;

    // Decide whether the new character extends the held character's token
    always_comb
    begin
        pos  = {1'b0, count_reg} + 7'd1;
        cont = 1'b0;
        case (held_kind_reg)
            etok_pkg::KIND_IDENT:
            begin
                cont = etok_pkg::is_ident(in_char) && (pos < 7'(etok_pkg::TOKEN_MAX));
            end
            etok_pkg::KIND_OP:
            begin
                if (etok_pkg::is_sign(held_char_reg))
                    cont = etok_pkg::is_sign(in_char) &&
                           (pos < 7'(etok_pkg::TOKEN_MAX));
                else if (count_reg != '0)
                    cont = 1'b0;
                else if ((held_char_reg == etok_pkg::CH_LT ||
                          held_char_reg == etok_pkg::CH_GT ||
                          held_char_reg == etok_pkg::CH_EQ ||
                          held_char_reg == etok_pkg::CH_BANG) &&
                         in_char == etok_pkg::CH_EQ)
                    cont = 1'b1;
                else if ((held_char_reg == etok_pkg::CH_AMP ||
                          held_char_reg == etok_pkg::CH_BAR) &&
                         in_char == held_char_reg)
                    cont = 1'b1;
                else
                    cont = 1'b0;
            end
            default:
            begin
                cont = 1'b0;
            end
        endcase
    end

    // Build the results and the next lookahead state
    always_comb
    begin
        new_kind = etok_pkg::kind_of(in_char);

        held_res.token_char      = held_char_reg;
        held_res.token_kind      = held_kind_reg;
        held_res.token_end       = ~cont;
        held_res.expression_done = 1'b0;
        held_res.item_last       = ~in_eoe;

        new_res.token_char      = in_char;
        new_res.token_kind      = new_kind;
        new_res.token_end       = 1'b1;
        new_res.expression_done = 1'b1;
        new_res.item_last       = 1'b1;

        push            = '0;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        held_kind_next  = held_kind_reg;
        count_next      = count_reg;

        if (in_fire)
        begin
            // Release the held character once its successor is known
            if (held_valid_reg)
            begin
                push.r0    = held_res;
                push.r1    = new_res;
                push.n     = in_eoe ? 2'd2 : 2'd1;
                count_next = cont ? count_reg + etok_pkg::CNT_W'(1) : '0;
            end
            else
            begin
                push.r0    = new_res;
                push.n     = in_eoe ? 2'd1 : 2'd0;
                count_next = '0;
            end

            // Hold the new character, or clear everything at end of expression
            if (in_eoe)
            begin
                held_char_next  = '0;
                held_valid_next = 1'b0;
                held_kind_next  = etok_pkg::KIND_IDENT;
                count_next      = '0;
            end
            else
            begin
                held_char_next  = in_char;
                held_valid_next = 1'b1;
                held_kind_next  = new_kind;
            end
        end
    end

    // Lookahead state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_kind_reg  <= etok_pkg::KIND_IDENT;
            count_reg      <= '0;
        end
        else
        begin
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            held_kind_reg  <= held_kind_next;
            count_reg      <= count_next;
        end
    end

endmodule

@@ design/etok_out_fifo.sv @@
// Four-entry result queue: takes up to two results a cycle, gives one while out_ready is high.
module etok_out_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  etok_pkg::push_t     push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output etok_pkg::res_t      out_res
);

    etok_pkg::res_t                 mem_reg [etok_pkg::FIFO_DEPTH];
    logic [etok_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [etok_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [etok_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic [etok_pkg::PTR_W-1:0]     wr_ptr_plus1;
    logic                           pop;

    assign room      = fill_reg <= etok_pkg::FILL_W'(etok_pkg::FIFO_DEPTH - 2);
    assign out_valid = fill_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + etok_pkg::PTR_W'(1);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + etok_pkg::PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + etok_pkg::PTR_W'(pop);
        fill_next   = fill_reg + etok_pkg::FILL_W'(push.n) - etok_pkg::FILL_W'(pop);
    end

    // Store incoming results
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.r1;
    end

    // Queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
